>>> rtl/solenoid_burst_pulse_controller_macros.svh
// Assertion helpers shared by the RTL.
`ifndef SOLENOID_BURST_PULSE_CONTROLLER_MACROS_SVH
`define SOLENOID_BURST_PULSE_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define SBPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define SBPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sbpc_pkg.sv
package sbpc_pkg;

  localparam int PULSE_W  = 11;
  localparam int PERIOD_W = 15;
  localparam int BURST_W  = 8;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;

  localparam logic [PERIOD_W-1:0] SAMPLE_TICK = 15'd300;
  localparam logic [BURST_W-1:0]  COUNT_MAX   = 8'd255;

  localparam logic [PULSE_W-1:0]  PULSE_RST  = 11'd800;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 15'd9000;
  localparam logic [BURST_W-1:0]  BURST_RST  = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_TICKS   = 2'd0,
    REG_PERIOD_TICKS  = 2'd1,
    REG_BURST_LENGTH  = 2'd2,
    REG_CUTOFF_ENABLE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PULSE_W-1:0]  pulse_ticks;
    logic [PERIOD_W-1:0] period_ticks;
    logic [BURST_W-1:0]  burst_length;
    logic                cutoff_enable;
  } cfg_t;

  typedef struct packed {
    logic               solenoid_on;
    logic               sample_request;
    logic               report_request;
    logic [BURST_W-1:0] shots_in_pull;
    logic               cycle_busy;
  } result_t;

endpackage

>>> rtl/sbpc_if.sv
interface sbpc_in_if;
  logic valid;
  logic ready;
  logic trigger_pressed;
  logic select_single;

  modport source (output valid, output trigger_pressed, output select_single, input ready);
  modport sink   (input valid, input trigger_pressed, input select_single, output ready);
endinterface

interface sbpc_out_if;
  logic       valid;
  logic       ready;
  logic       solenoid_on;
  logic       sample_request;
  logic       report_request;
  logic [7:0] shots_in_pull;
  logic       cycle_busy;

  modport source (output valid, output solenoid_on, output sample_request,
                  output report_request, output shots_in_pull, output cycle_busy,
                  input ready);
  modport sink   (input valid, input solenoid_on, input sample_request,
                  input report_request, input shots_in_pull, input cycle_busy,
                  output ready);
endinterface

>>> rtl/solenoid_burst_pulse_controller.sv
// Channel   Dir  Beat contents
// in_ch     in   trigger_pressed, select_single (one timer tick)
// out_ch    out  solenoid_on, sample_request, report_request, shots_in_pull, cycle_busy
// cfg_*     in   cfg_we, cfg_idx, cfg_wdata (write only)
//
// One beat in, one out, via input and result registers; a tick per cycle unless stalled.
// The rate is set by the single state update per tick in sbpc_tick.
// rst_n is synchronous, active low; configuration returns to 800/9000/3/0.
// A stalled output holds its register; the input register refills as soon as it drains.
`include "solenoid_burst_pulse_controller_macros.svh"

module solenoid_burst_pulse_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  sbpc_in_if.sink                         in_ch,
  sbpc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sbpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sbpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sbpc_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic    in_valid_r;
  logic    trig_r;
  logic    single_r;
  logic    out_valid_r;
  result_t out_r;

  // advance the pipe when the output register is empty or being taken
  logic adv;
  logic fire;
  logic in_take;

  assign adv     = !out_valid_r || out_ch.ready;
  assign fire    = in_valid_r && adv;
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !in_valid_r || adv;

  sbpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sbpc_tick u_tick (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .trigger_pressed (trig_r),
    .select_single   (single_r),
    .cfg             (cfg),
    .res             (res)
  );

  // input register: hold the pin levels of the waiting tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      trig_r   <= in_ch.trigger_pressed;
      single_r <= in_ch.select_single;
    end
  end

  // result register: valid moves on every advance, data loads on fire; a bubble drops the valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.solenoid_on    = out_r.solenoid_on;
  assign out_ch.sample_request = out_r.sample_request;
  assign out_ch.report_request = out_r.report_request;
  assign out_ch.shots_in_pull  = out_r.shots_in_pull;
  assign out_ch.cycle_busy     = out_r.cycle_busy;

  `SBPC_ASSERT_NXT(a_fire_fills_out, fire, out_valid_r, "processed tick lost")
  `SBPC_ASSERT_NXT(a_bubble_passes, adv && !in_valid_r, !out_valid_r, "result invented")
  `SBPC_ASSERT_NXT(a_take_fills_in, in_take, in_valid_r, "accepted tick dropped")

endmodule

>>> rtl/sbpc_cfg.sv
module sbpc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sbpc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [sbpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sbpc_pkg::cfg_t                   cfg
);
  import sbpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_PULSE_TICKS:   cfg_nxt.pulse_ticks   = cfg_wdata[PULSE_W-1:0];
        REG_PERIOD_TICKS:  cfg_nxt.period_ticks  = cfg_wdata[PERIOD_W-1:0];
        REG_BURST_LENGTH:  cfg_nxt.burst_length  = cfg_wdata[BURST_W-1:0];
        REG_CUTOFF_ENABLE: cfg_nxt.cutoff_enable = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_ticks   <= PULSE_RST;
      cfg_r.period_ticks  <= PERIOD_RST;
      cfg_r.burst_length  <= BURST_RST;
      cfg_r.cutoff_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/sbpc_tick.sv
`include "solenoid_burst_pulse_controller_macros.svh"

module sbpc_tick (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              trigger_pressed,
  input  logic              select_single,
  input  sbpc_pkg::cfg_t    cfg,
  output sbpc_pkg::result_t res
);
  import sbpc_pkg::*;

  logic [PERIOD_W-1:0] cycle_tick_r, cycle_tick_nxt;
  logic                running_r, running_nxt;
  logic                armed_r, armed_nxt;
  logic [BURST_W-1:0]  shot_count_r, shot_count_nxt;
  logic [BURST_W-1:0]  spp_r, spp_nxt;
  logic                drive_r, drive_nxt;

  logic [PERIOD_W-1:0] tick_adv;
  logic                sample_hit;
  logic                report_hit;
  logic                pulse_hit;
  logic                period_hit;

  always_comb begin
    tick_adv   = cycle_tick_r + 15'd1;
    sample_hit = running_r && (tick_adv == SAMPLE_TICK);
    report_hit = running_r && ({1'b0, tick_adv} == {4'd0, cfg.pulse_ticks, 1'b0});
    pulse_hit  = running_r && (tick_adv == {4'd0, cfg.pulse_ticks});
    period_hit = running_r && (tick_adv == cfg.period_ticks);

    cycle_tick_nxt = running_r ? tick_adv : cycle_tick_r;
    running_nxt    = running_r;
    armed_nxt      = armed_r;
    shot_count_nxt = shot_count_r;
    spp_nxt        = spp_r;
    drive_nxt      = drive_r;

    // end of pulse wins over end of period
    if (pulse_hit) begin
      drive_nxt = 1'b0;
      if (shot_count_r != COUNT_MAX) begin
        shot_count_nxt = shot_count_r + 8'd1;
      end
      if ((cfg.cutoff_enable && (shot_count_nxt >= spp_r)) || (spp_r == 8'd1)) begin
        armed_nxt = 1'b0;
      end
    end else if (period_hit) begin
      cycle_tick_nxt = '0;
      running_nxt    = 1'b0;
    end

    if (!running_nxt) begin
      spp_nxt = select_single ? 8'd1 : cfg.burst_length;
    end

    if (trigger_pressed) begin
      if (!running_nxt && armed_nxt) begin
        running_nxt    = 1'b1;
        drive_nxt      = 1'b1;
        cycle_tick_nxt = '0;
      end
    end else begin
      armed_nxt      = 1'b1;
      shot_count_nxt = '0;
    end

    res.solenoid_on    = drive_nxt;
    res.sample_request = sample_hit;
    res.report_request = report_hit;
    res.shots_in_pull  = shot_count_nxt;
    res.cycle_busy     = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_tick_r <= '0;
      running_r    <= 1'b0;
      armed_r      <= 1'b0;
      shot_count_r <= '0;
      spp_r        <= '0;
      drive_r      <= 1'b0;
    end else if (fire) begin
      cycle_tick_r <= cycle_tick_nxt;
      running_r    <= running_nxt;
      armed_r      <= armed_nxt;
      shot_count_r <= shot_count_nxt;
      spp_r        <= spp_nxt;
      drive_r      <= drive_nxt;
    end
  end

  `SBPC_ASSERT_NXT(a_release_clears, fire && !trigger_pressed, shot_count_r == 8'd0, "count not cleared on release")
  `SBPC_ASSERT_NXT(a_count_monotonic, 1'b1, (shot_count_r >= $past(shot_count_r)) || (shot_count_r == 8'd0), "shot count fell")
  `SBPC_ASSERT_NXT(a_hold_when_idle, !fire, $stable(cycle_tick_r) && $stable(running_r), "state moved without a tick")

endmodule

>>> sim/solenoid_burst_pulse_controller_test.sv
module solenoid_burst_pulse_controller_test;
  import sbpc_pkg::*;

  // Give up after this many cycles without a single beat on either channel.
  localparam int WATCHDOG_LIMIT = 1000;
  // Pipeline depth plus margin: wait this long after the last result before a write.
  localparam int SETTLE_CYCLES = 4;

  // Directed drill: one row drives the same pins for reps ticks. A row can first load a new
  // setting, and can carry a result that is known by inspection.
  typedef struct {
    logic    has_cfg;
    cfg_t    setting;
    logic    pressed;
    logic    single;
    int      reps;
    logic    pinned;
    result_t want;
  } drill_row_t;

  // Random workload: a setting, a tick budget and the shape of the trigger pulls.
  typedef struct {
    cfg_t setting;
    int   ticks;
    int   hold_min;
    int   hold_max;
    logic noisy;
    logic burst_only;
  } workload_t;

  localparam cfg_t    KEEP_CFG   = '0;
  localparam result_t ALL_LOW    = '0;
  localparam result_t FIRST_SHOT = '{solenoid_on: 1'b1, sample_request: 1'b0,
                                     report_request: 1'b0, shots_in_pull: 8'd0,
                                     cycle_busy: 1'b1};

  localparam int DRILL_ROWS = 10;
  localparam int WORKLOADS  = 7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sbpc_in_if  in_ch();
  sbpc_out_if out_ch();

  solenoid_burst_pulse_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Reset state and the short special cases. Rows without a typed result are predicted.
  drill_row_t drill_rows [DRILL_ROWS] = '{
    // Trigger pressed straight out of reset: not armed yet, nothing moves.
    '{1'b0, KEEP_CFG, 1'b1, 1'b0, 1, 1'b1, ALL_LOW},
    // Release arms the block; still idle.
    '{1'b0, KEEP_CFG, 1'b0, 1'b1, 1, 1'b1, ALL_LOW},
    // Burst of two with cutoff: first press fires at once.
    '{1'b1, '{11'd1, 15'd2, 8'd2, 1'b1}, 1'b1, 1'b0, 1, 1'b1, FIRST_SHOT},
    '{1'b0, KEEP_CFG, 1'b1, 1'b0, 5, 1'b0, ALL_LOW},
    '{1'b0, KEEP_CFG, 1'b0, 1'b1, 1, 1'b0, ALL_LOW},
    // Pulse equal to period: the pulse end wins and the cycle keeps running.
    '{1'b1, '{11'd2, 15'd2, 8'd1, 1'b0}, 1'b1, 1'b1, 4, 1'b0, ALL_LOW},
    // Period shorter than pulse: the cycle ends with the solenoid still driven.
    '{1'b1, '{11'd3, 15'd2, 8'd3, 1'b0}, 1'b0, 1'b0, 1, 1'b0, ALL_LOW},
    '{1'b0, KEEP_CFG, 1'b1, 1'b0, 3, 1'b0, ALL_LOW},
    // Zero pulse: the drive is never dropped short of a counter wrap.
    '{1'b1, '{11'd0, 15'd2, 8'd3, 1'b0}, 1'b1, 1'b0, 3, 1'b0, ALL_LOW},
    // Burst length zero with cutoff: disarm on the very first shot.
    '{1'b1, '{11'd1, 15'd2, 8'd0, 1'b1}, 1'b1, 1'b0, 3, 1'b0, ALL_LOW}
  };

  // Short cycles first, then the register extremes; the last workload runs without gaps.
  workload_t feed_plan [WORKLOADS] = '{
    '{'{11'd3,    15'd9,     8'd3,   1'b1}, 40,  1,   40,  1'b1, 1'b0},
    '{'{11'd5,    15'd12,    8'd2,   1'b0}, 40,  1,   40,  1'b1, 1'b0},
    // Long cycle: reaches the sample tick and twice the pulse length.
    '{'{11'd200,  15'd5000,  8'd2,   1'b1}, 420, 1,   60,  1'b1, 1'b0},
    // Two-tick cycles held for over 510 ticks: drives the shot count into saturation.
    '{'{11'd1,    15'd2,     8'd250, 1'b0}, 520, 512, 520, 1'b0, 1'b1},
    '{'{11'd2000, 15'd20000, 8'd250, 1'b1}, 20,  5,   20,  1'b1, 1'b0},
    '{'{11'd2047, 15'd32767, 8'd255, 1'b0}, 15,  5,   15,  1'b1, 1'b0},
    '{'{11'd4,    15'd10,    8'd2,   1'b1}, 30,  1,   30,  1'b1, 1'b0}
  };

  // Shadow copy of the controller: registers and per-tick state.
  cfg_t                shot_cfg = '{PULSE_RST, PERIOD_RST, BURST_RST, 1'b0};
  logic [PERIOD_W-1:0] cyc_tick    = '0;
  logic                cyc_running = 1'b0;
  logic                cyc_armed   = 1'b0;
  logic                cyc_drive   = 1'b0;
  logic [BURST_W-1:0]  pull_shots  = '0;
  logic [BURST_W-1:0]  pull_limit  = '0;

  result_t tick_results_q [$];
  int      mismatches   = 0;
  int      quiet_cycles = 0;
  int      stall_left   = 0;
  logic    idling_on    = 1'b0;

  // Typed expectation travelling alongside the beat, driven like the payload.
  logic    pinned_valid  = 1'b0;
  result_t pinned_result = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the shadow state by one timer tick and return the beat it should produce.
  function automatic result_t fire_tick(input logic pressed, input logic single);
    result_t r;
    r = '0;
    if (cyc_running) begin
      cyc_tick = cyc_tick + 1'b1;
      if (cyc_tick == SAMPLE_TICK)
        r.sample_request = 1'b1;
      if (int'(cyc_tick) == 2 * int'(shot_cfg.pulse_ticks))
        r.report_request = 1'b1;
      // Pulse end takes priority over period end when both match.
      if (cyc_tick == {4'd0, shot_cfg.pulse_ticks}) begin
        cyc_drive = 1'b0;
        if (pull_shots != COUNT_MAX)
          pull_shots = pull_shots + 1'b1;
        if ((shot_cfg.cutoff_enable && pull_shots >= pull_limit) || pull_limit == 8'd1)
          cyc_armed = 1'b0;
      end else if (cyc_tick == shot_cfg.period_ticks) begin
        cyc_tick    = '0;
        cyc_running = 1'b0;
      end
    end
    // The mode pin only counts while no cycle runs.
    if (!cyc_running)
      pull_limit = single ? 8'd1 : shot_cfg.burst_length;
    if (pressed) begin
      if (!cyc_running && cyc_armed) begin
        cyc_running = 1'b1;
        cyc_drive   = 1'b1;
        cyc_tick    = '0;
      end
    end else begin
      // Release re-arms and clears the count, even mid-cycle.
      cyc_armed  = 1'b1;
      pull_shots = '0;
    end
    r.solenoid_on   = cyc_drive;
    r.shots_in_pull = pull_shots;
    r.cycle_busy    = cyc_running;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [BURST_W-1:0] want,
                               input logic [BURST_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Shadow register writes, predict accepted ticks, check result beats, run the watchdog.
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PULSE_TICKS:   shot_cfg.pulse_ticks   = cfg_wdata[PULSE_W-1:0];
          REG_PERIOD_TICKS:  shot_cfg.period_ticks  = cfg_wdata[PERIOD_W-1:0];
          REG_BURST_LENGTH:  shot_cfg.burst_length  = cfg_wdata[BURST_W-1:0];
          REG_CUTOFF_ENABLE: shot_cfg.cutoff_enable = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        want = fire_tick(in_ch.trigger_pressed, in_ch.select_single);
        if (pinned_valid)
          want = pinned_result;
        tick_results_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tick_results_q.size() == 0) begin
          $error("result beat with no tick outstanding");
          mismatches++;
        end else begin
          want = tick_results_q.pop_front();
          compare_field("solenoid_on", want.solenoid_on, out_ch.solenoid_on);
          compare_field("sample_request", want.sample_request, out_ch.sample_request);
          compare_field("report_request", want.report_request, out_ch.report_request);
          compare_field("shots_in_pull", want.shots_in_pull, out_ch.shots_in_pull);
          compare_field("cycle_busy", want.cycle_busy, out_ch.cycle_busy);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side: while idling is on, drop ready at random for a random stall length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offer one tick, with an optional gap in front, and hold it until it is taken.
  task automatic send_tick(input logic pressed, input logic single,
                           input logic pin, input result_t pin_val);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.trigger_pressed <= pressed;
    in_ch.select_single   <= single;
    pinned_valid          <= pin;
    pinned_result         <= pin_val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering ticks and wait until every predicted beat has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Load a full setting. A cycle left running is first wound down by pulling the period
  // in just ahead of the current tick, so that no setting inherits a counter stuck past
  // both compare points.
  task automatic apply_setting(input cfg_t s);
    logic [PERIOD_W-1:0] stop_at;
    drain_results();
    if (cyc_running) begin
      stop_at = cyc_tick + 15'd4;
      if (stop_at == {4'd0, shot_cfg.pulse_ticks})
        stop_at = stop_at + 1'b1;
      write_reg(REG_PERIOD_TICKS, stop_at);
      // Released ticks never restart, so six of them leave the block idle.
      repeat (6) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0, ALL_LOW);
      drain_results();
    end
    write_reg(REG_PULSE_TICKS, s.pulse_ticks);
    write_reg(REG_PERIOD_TICKS, s.period_ticks);
    write_reg(REG_BURST_LENGTH, s.burst_length);
    write_reg(REG_CUTOFF_ENABLE, s.cutoff_enable);
  endtask

  initial begin
    int   remaining;
    int   span;
    logic mode;
    logic paused;
    logic last_load;

    in_ch.valid           = 1'b0;
    in_ch.trigger_pressed = 1'b0;
    in_ch.select_single   = 1'b0;
    paused                = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed drill.
    idling_on = 1'b1;
    foreach (drill_rows[r]) begin
      if (drill_rows[r].has_cfg)
        apply_setting(drill_rows[r].setting);
      for (int k = 0; k < drill_rows[r].reps; k++)
        send_tick(drill_rows[r].pressed, drill_rows[r].single,
                  drill_rows[r].pinned, drill_rows[r].want);
    end

    // Random workloads: mostly release-then-hold trigger pulls of random length,
    // with a sprinkle of loose random ticks between pulls.
    foreach (feed_plan[p]) begin
      apply_setting(feed_plan[p].setting);
      remaining = feed_plan[p].ticks;
      last_load = (p == WORKLOADS - 1);
      while (remaining > 0) begin
        idling_on = !last_load && ($urandom_range(0, 3) != 0);
        // Hold the sender back once until the pipe is empty.
        if (p == 1 && !paused && remaining < feed_plan[p].ticks / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if (feed_plan[p].noisy && $urandom_range(0, 7) == 0) begin
          span = $urandom_range(1, 3);
          for (int k = 0; k < span && remaining > 0; k++) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, ALL_LOW);
            remaining--;
          end
        end
        mode = feed_plan[p].burst_only ? 1'b0 : 1'($urandom_range(0, 1));
        span = $urandom_range(1, 4);
        for (int k = 0; k < span && remaining > 0; k++) begin
          send_tick(1'b0, mode, 1'b0, ALL_LOW);
          remaining--;
        end
        span = $urandom_range(feed_plan[p].hold_min, feed_plan[p].hold_max);
        for (int k = 0; k < span && remaining > 0; k++) begin
          // Flip the mode pin now and then mid-pull, except where the burst must survive.
          if (!feed_plan[p].burst_only && $urandom_range(0, 9) == 0)
            send_tick(1'b1, !mode, 1'b0, ALL_LOW);
          else
            send_tick(1'b1, mode, 1'b0, ALL_LOW);
          remaining--;
        end
      end
    end

    idling_on = 1'b0;
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && tick_results_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/sbpc_pkg.sv
rtl/sbpc_if.sv
rtl/sbpc_cfg.sv
rtl/sbpc_tick.sv
rtl/solenoid_burst_pulse_controller.sv
sim/solenoid_burst_pulse_controller_test.sv
